### design/wasc_pkg.sv
// wasc_pkg: shared types, constants and helpers of the windowed absolute sum core
`default_nettype none

package wasc_pkg;

	// stream geometry
	localparam int WINDOW   = 256;
	localparam int GROUPS   = 2;
	localparam int LAYERS   = 4;
	localparam int STREAMS  = GROUPS * LAYERS;
	localparam int SENSORS  = 3;

	// derived widths
	localparam int STREAM_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int POS_W    = $clog2(WINDOW);
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int RING_D   = STREAMS * WINDOW;
	localparam int ADDR_W   = $clog2(RING_D);
	localparam int ABS_W    = 17;
	localparam int SUM_W    = $clog2(WINDOW * 32768 + 1);
	localparam int OUT_W    = 24;
	localparam logic [31:0] OUT_MAX = 32'h00FF_FFFF;

	// input transaction
	typedef struct packed {
		logic              group;
		logic [1:0]        layer;
		logic signed [15:0] reading_a;
		logic signed [15:0] reading_b;
		logic signed [15:0] reading_c;
	} sample_t;

	// output transaction
	typedef struct packed {
		logic              out_group;
		logic [1:0]        out_layer;
		logic [OUT_W-1:0]  abs_sum_a;
		logic [OUT_W-1:0]  abs_sum_b;
		logic [OUT_W-1:0]  abs_sum_c;
	} result_t;

	// one ring entry: the three raw readings
	typedef logic [SENSORS-1:0][15:0] ring_word_t;

	// issue information from the stream controller
	typedef struct packed {
		logic                hit;
		logic [STREAM_W-1:0] stream;
		logic                full;
		logic                all_full;
		logic [ADDR_W-1:0]   addr;
	} issue_t;

	// absolute value of a 16-bit two's complement reading
	function automatic logic [ABS_W-1:0] abs17(input logic [15:0] x);
		logic [ABS_W-1:0] ext;
		ext = {x[15], x};
		return x[15] ? (ABS_W'(0) - ext) : ext;
	endfunction

endpackage

`default_nettype wire

### design/windowed_absolute_sum_core.sv
// windowed_absolute_sum_core: top level, sum update pipeline and result register
//
// Each sample transaction (sample_valid/sample_ready, payload sample) carries
// three signed readings for the stream picked by group and layer. The core
// keeps the last WINDOW samples of every stream in a single-port ring memory
// and a running sum of absolute values per sensor. Once every stream holds a
// full window, each sample produces one result transaction (result_valid /
// result_ready, payload result) with the three window sums of its stream;
// before that, samples are stored and summed but give no result. Samples for
// a stream outside the configured groups/layers are taken and ignored.
// A result passes through stage 1 and then the result register before it is presented.
// Throughput: one sample per cycle while no stall holds the pipeline, set by
// the one read-first ring access each sample makes at its stream's write slot.
// Reset (arst_n low) clears positions, fill counts, sums and all valid flags;
// ring contents need no clearing, so samples are accepted right after reset.
// While the result register is full and result_ready is low, the pipeline
// holds and sample_ready drops once a sample waits behind the result.
`default_nettype none

module windowed_absolute_sum_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_ready,
	input  wire wasc_pkg::sample_t  sample,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output wasc_pkg::result_t       result
);

	wasc_pkg::issue_t              issue;
	wasc_pkg::ring_word_t          wdata;
	wasc_pkg::ring_word_t          rdata;
	logic                          accept;
	logic                          stall;
	logic                          done_s1;

	logic                          valid_s1;
	logic [wasc_pkg::STREAM_W-1:0] stream_s1;
	logic                          group_s1;
	logic [1:0]                    layer_s1;
	logic                          full_s1;
	logic                          all_full_s1;
	logic [wasc_pkg::ABS_W-1:0]    new_abs_s1 [wasc_pkg::SENSORS];

	logic [wasc_pkg::SUM_W-1:0]    sum_q   [wasc_pkg::STREAMS][wasc_pkg::SENSORS];
	logic [wasc_pkg::SUM_W-1:0]    sum_new [wasc_pkg::SENSORS];
	logic [wasc_pkg::OUT_W-1:0]    sum_out [wasc_pkg::SENSORS];
	logic                          out_valid_q;
	wasc_pkg::result_t             out_q;

	// handshake and stall
	always_comb begin
		stall        = valid_s1 && out_valid_q && !result_ready;
		sample_ready = !stall;
		accept       = sample_valid && sample_ready;
		done_s1      = valid_s1 && !stall;
		wdata        = {sample.reading_c, sample.reading_b, sample.reading_a};
	end

	wasc_stream_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.group  (sample.group),
		.layer  (sample.layer),
		.issue  (issue)
	);

	wasc_ring u_ring (
		.clk   (clk),
		.en    (accept && issue.hit),
		.addr  (issue.addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= issue.hit;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			stream_s1     <= issue.stream;
			group_s1      <= sample.group;
			layer_s1      <= sample.layer;
			full_s1       <= issue.full;
			all_full_s1   <= issue.all_full;
			new_abs_s1[0] <= wasc_pkg::abs17(sample.reading_a);
			new_abs_s1[1] <= wasc_pkg::abs17(sample.reading_b);
			new_abs_s1[2] <= wasc_pkg::abs17(sample.reading_c);
		end
	end

	// running sum update: drop the oldest once full, add the newest
	always_comb begin
		for (int k = 0; k < wasc_pkg::SENSORS; k++) begin
			sum_new[k] = sum_q[stream_s1][k]
			           - (full_s1 ? wasc_pkg::SUM_W'(wasc_pkg::abs17(rdata[k])) : '0)
			           + wasc_pkg::SUM_W'(new_abs_s1[k]);
			if (32'(sum_new[k]) > wasc_pkg::OUT_MAX) begin
				sum_out[k] = '1;
			end else begin
				sum_out[k] = wasc_pkg::OUT_W'(sum_new[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wasc_pkg::STREAMS; i++) begin
				for (int k = 0; k < wasc_pkg::SENSORS; k++) begin
					sum_q[i][k] <= '0;
				end
			end
		end else if (done_s1) begin
			for (int k = 0; k < wasc_pkg::SENSORS; k++) begin
				sum_q[stream_s1][k] <= sum_new[k];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1 && all_full_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && all_full_s1) begin
			out_q.out_group <= group_s1;
			out_q.out_layer <= layer_s1;
			out_q.abs_sum_a <= sum_out[0];
			out_q.abs_sum_b <= sum_out[1];
			out_q.abs_sum_c <= sum_out[2];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// a pending sample behind an untaken result blocks new transactions
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result_ready |-> !sample_ready)
		else $error("sample taken while pipeline is stalled");

	// an out-of-range stream never enters the pipeline
	a_drop_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !issue.hit |=> !valid_s1)
		else $error("unmapped stream entered the pipeline");

	// a completing sample with all windows full shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && all_full_s1 |=> result_valid)
		else $error("result missing after full-window sample");

endmodule

`default_nettype wire

### design/wasc_ring.sv
// wasc_ring: single-port read-first sample ring memory with registered read data
`default_nettype none

module wasc_ring (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [wasc_pkg::ADDR_W-1:0] addr,
	input  wire wasc_pkg::ring_word_t        wdata,
	output wasc_pkg::ring_word_t             rdata
);

	wasc_pkg::ring_word_t mem [wasc_pkg::RING_D];

	// old entry comes out while the new one goes in
	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

`default_nettype wire

### design/wasc_stream_ctrl.sv
// wasc_stream_ctrl: per-stream write position and fill count, ring address generation
`default_nettype none

module wasc_stream_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          group,
	input  wire logic [1:0]    layer,
	output wasc_pkg::issue_t   issue
);

	logic [wasc_pkg::POS_W-1:0]    pos_q  [wasc_pkg::STREAMS];
	logic [wasc_pkg::FILL_W-1:0]   fill_q [wasc_pkg::STREAMS];
	logic [wasc_pkg::STREAM_W-1:0] stream;
	logic                          hit;
	logic                          full;
	logic [wasc_pkg::POS_W-1:0]    pos;
	logic [wasc_pkg::STREAMS-1:0]  full_next;

	// stream selection and range check
	always_comb begin
		hit    = (32'(group) < wasc_pkg::GROUPS) && (32'(layer) < wasc_pkg::LAYERS);
		stream = wasc_pkg::STREAM_W'(32'(group) * wasc_pkg::LAYERS + 32'(layer));
		pos    = pos_q[stream];
		full   = (fill_q[stream] == wasc_pkg::FILL_W'(wasc_pkg::WINDOW));
	end

	// window state of every stream once this sample is counted
	always_comb begin
		for (int i = 0; i < wasc_pkg::STREAMS; i++) begin
			full_next[i] = (fill_q[i] == wasc_pkg::FILL_W'(wasc_pkg::WINDOW));
		end
		if (hit && (fill_q[stream] == wasc_pkg::FILL_W'(wasc_pkg::WINDOW - 1))) begin
			full_next[stream] = 1'b1;
		end
	end

	always_comb begin
		issue.hit      = hit;
		issue.stream   = stream;
		issue.full     = full;
		issue.all_full = &full_next;
		issue.addr     = wasc_pkg::ADDR_W'(32'(stream) * wasc_pkg::WINDOW) +
		                 wasc_pkg::ADDR_W'(pos);
	end

	// advance position and fill of the addressed stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wasc_pkg::STREAMS; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (accept && hit) begin
			if (pos == wasc_pkg::POS_W'(wasc_pkg::WINDOW - 1)) begin
				pos_q[stream] <= '0;
			end else begin
				pos_q[stream] <= pos + 1'b1;
			end
			if (!full) begin
				fill_q[stream] <= fill_q[stream] + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### tb/tb_windowed_absolute_sum_core.sv
// tb_windowed_absolute_sum_core: randomized self-checking testbench of the windowed absolute sum core
`timescale 1ns / 1ps

module tb_windowed_absolute_sum_core;
	import wasc_pkg::*;

	localparam int STALL_LIMIT   = 500;
	localparam int RANDOM_ITEMS  = 1350;
	localparam int DIRECTED_ITEMS = 16;

	// readings at the corners of the signed range
	localparam logic signed [15:0] EXTREMES [5] = '{
		16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001
	};

	// window contents and absolute sums per stream, plus the results they imply
	class window_sum_tracker;
		bit [15:0] history [STREAMS][WINDOW][SENSORS];
		bit [31:0] sums [STREAMS][SENSORS];
		int unsigned slot [STREAMS];
		int unsigned depth [STREAMS];
		result_t awaited [$];
		int failures;

		function bit [31:0] magnitude(bit [15:0] x);
			return x[15] ? (32'h10000 - {16'h0, x}) : {16'h0, x};
		endfunction

		function bit [OUT_W-1:0] clip(bit [31:0] v);
			return (v > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : v[OUT_W-1:0];
		endfunction

		// update the stream's window with one accepted sample transaction
		function void take_sample(sample_t s);
			int st;
			bit wrapped;
			bit [15:0] rd [SENSORS];
			result_t r;

			if (s.group >= GROUPS || s.layer >= LAYERS)
				return;
			st = int'(s.group) * LAYERS + int'(s.layer);
			rd[0] = s.reading_a;
			rd[1] = s.reading_b;
			rd[2] = s.reading_c;
			wrapped = depth[st] >= WINDOW;
			for (int k = 0; k < SENSORS; k++) begin
				if (wrapped)
					sums[st][k] -= magnitude(history[st][slot[st]][k]);
				sums[st][k] += magnitude(rd[k]);
				history[st][slot[st]][k] = rd[k];
			end
			slot[st] = (slot[st] + 1) % WINDOW;
			if (!wrapped)
				depth[st]++;

			// no result until every stream holds a full window
			foreach (depth[i])
				if (depth[i] < WINDOW)
					return;
			r.out_group = s.group;
			r.out_layer = s.layer;
			r.abs_sum_a = clip(sums[st][0]);
			r.abs_sum_b = clip(sums[st][1]);
			r.abs_sum_c = clip(sums[st][2]);
			awaited = {awaited, r};
		endfunction

		// compare one result transaction with the oldest expected one
		function void match_result(result_t got);
			result_t want;

			if (awaited.size() == 0) begin
				$error("unexpected result: group %0d layer %0d sums %0d %0d %0d",
					got.out_group, got.out_layer, got.abs_sum_a, got.abs_sum_b,
					got.abs_sum_c);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got.out_group !== want.out_group) begin
				$error("out_group: expected %0d, got %0d", want.out_group, got.out_group);
				failures++;
			end
			if (got.out_layer !== want.out_layer) begin
				$error("out_layer: expected %0d, got %0d", want.out_layer, got.out_layer);
				failures++;
			end
			if (got.abs_sum_a !== want.abs_sum_a) begin
				$error("abs_sum_a: expected %0d, got %0d", want.abs_sum_a, got.abs_sum_a);
				failures++;
			end
			if (got.abs_sum_b !== want.abs_sum_b) begin
				$error("abs_sum_b: expected %0d, got %0d", want.abs_sum_b, got.abs_sum_b);
				failures++;
			end
			if (got.abs_sum_c !== want.abs_sum_c) begin
				$error("abs_sum_c: expected %0d, got %0d", want.abs_sum_c, got.abs_sum_c);
				failures++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	window_sum_tracker tracker;
	int fed [STREAMS];
	int sender_calm = 0;
	int reader_calm = 0;
	int stalled_cycles = 0;

	windowed_absolute_sum_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle cycles before the next transaction, with runs of back-to-back traffic
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// reading biased toward the range corners
	function automatic logic signed [15:0] pick_reading();
		if ($urandom_range(0, 4) == 0)
			return EXTREMES[$urandom_range(0, 4)];
		return 16'($urandom);
	endfunction

	// offer one sample transaction and hold it until accepted
	task automatic send_sample(input int stream, input logic signed [15:0] a,
			input logic signed [15:0] b, input logic signed [15:0] c);
		sample_t item;
		int gap;

		item.group     = 1'(stream / LAYERS);
		item.layer     = 2'(stream % LAYERS);
		item.reading_a = a;
		item.reading_b = b;
		item.reading_c = c;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= item;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		fed[stream]++;
	endtask

	// observe both channels and track progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				tracker.take_sample(sample);
			if (result_valid && result_ready)
				tracker.match_result(result);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
	end

	// result side: random back-pressure
	initial begin
		int gap;

		@(posedge arst_n);
		forever begin
			gap = pick_gap(reader_calm);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// watchdog on a hung handshake
	initial begin
		wait (stalled_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int s;
		int short;
		int burst_at;

		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every stream twice with corner readings, including the most negative
		for (int n = 0; n < DIRECTED_ITEMS; n++)
			send_sample(n % STREAMS, EXTREMES[n % 5], EXTREMES[(n + 2) % 5],
				EXTREMES[(n + 4) % 5]);

		// fill every window, mostly steering toward streams still short of samples
		do begin
			s = $urandom_range(0, STREAMS - 1);
			if (fed[s] >= WINDOW && $urandom_range(0, 3) != 0)
				foreach (fed[i])
					if (fed[i] < WINDOW)
						s = i;
			send_sample(s, pick_reading(), pick_reading(), pick_reading());
			short = 0;
			foreach (fed[i])
				if (fed[i] < WINDOW)
					short++;
		end while (short != 0);

		// steady state: one result per sample, with one window driven to its largest sum
		burst_at = $urandom_range(200, 1000);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == burst_at) begin
				s = $urandom_range(0, STREAMS - 1);
				repeat (WINDOW + 4)
					send_sample(s, 16'sh8000, 16'sh8000, 16'sh8000);
			end
			send_sample($urandom_range(0, STREAMS - 1), pick_reading(), pick_reading(),
				pick_reading());
		end
		sample_valid <= 1'b0;

		// drain, then keep watching to catch stray results
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
